// ----- rtl/core/crhc_pkg.sv -----
// crhc_pkg: shared types, field widths, operation codes and the inside-ness
// combine function of the csg ray hit combiner
// no dependencies
package crhc_pkg;

  localparam int DIST_W = 32;
  localparam int TAG_W  = 16;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_UNION     = 2'd0;
  localparam logic [OP_W-1:0] OP_INTERSECT = 2'd1;
  localparam logic [OP_W-1:0] OP_SUBTRACT  = 2'd2;

  // one result item as it leaves the block
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              entering;
    logic [TAG_W-1:0]  tag;
    logic              no_crossing;
    logic              overflowed;
    logic              last_result;
  } result_t;

  // combined inside-ness of the two children
  function automatic logic combine(input logic [OP_W-1:0] op, input logic a,
                                   input logic b);
    logic r;
    case (op)
      OP_UNION:     r = a | b;
      OP_INTERSECT: r = a & b;
      OP_SUBTRACT:  r = a & ~b;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/crhc_ifs.sv -----
// crhc_ifs: valid/ready channel interfaces for hits, results and configuration
// depends on crhc_pkg
interface crhc_hit_if;
  import crhc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     carries_hit;
  logic signed [DIST_W-1:0] hit_distance;
  logic                     from_second;
  logic                     hit_entering;
  logic [TAG_W-1:0]         hit_tag;
  logic                     last_hit;

  modport source (output valid, carries_hit, hit_distance, from_second, hit_entering,
                  hit_tag, last_hit, input ready);
  modport sink (input valid, carries_hit, hit_distance, from_second, hit_entering,
                hit_tag, last_hit, output ready);
endinterface

interface crhc_res_if;
  import crhc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] out_distance;
  logic                     out_entering;
  logic [TAG_W-1:0]         out_tag;
  logic                     no_crossing;
  logic                     overflowed;
  logic                     last_result;

  modport source (output valid, out_distance, out_entering, out_tag, no_crossing,
                  overflowed, last_result, input ready);
  modport sink (input valid, out_distance, out_entering, out_tag, no_crossing,
                overflowed, last_result, output ready);
endinterface

interface crhc_cfg_if;
  import crhc_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;

  modport source (output valid, operation, input ready);
  modport sink (input valid, operation, output ready);
endinterface

// ----- rtl/core/csg_ray_hit_combiner.sv -----
// csg_ray_hit_combiner: top level, sequencer with the shared signed compare
// depends on crhc_pkg, crhc_ifs, crhc_hit_mem and crhc_out_reg
//
// Usage
//   hits: one child hit per item (distance, side, entering, tag); an item with
//   carries_hit low is an empty marker. last_hit closes a run.
//   results: the boundary crossings of the combined shape in distance order,
//   last_result on the final one. A run without crossings gives one item
//   with no_crossing set. overflowed is set on every result of a run that
//   had more than HITS hits.
//   cfg: writes the operation register (union, intersection, subtraction).
// Timing
//   a hit is insertion-sorted into the store as it arrives: the shared
//   compare walks down the stored hits one per cycle. A last item then
//   starts the walk over the sorted store, one hit per cycle unless a
//   crossing finds the output slot full; hits is not ready meanwhile.
//   The store has one read and one write port.
// Reset clears the run state and the operation register; the store needs no
// clearing. When the receiver stalls, the walk holds with a result waiting
// in the output register and one more in the lookahead register.
module csg_ray_hit_combiner #(
  parameter int HITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  crhc_hit_if.sink   hits,
  crhc_res_if.source results,
  crhc_cfg_if.sink   cfg
);
  import crhc_pkg::*;

  localparam int AW = $clog2(HITS);
  localparam int CW = $clog2(HITS + 1);
  localparam int EW = DIST_W + TAG_W + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCMP   = 3'd1;
  localparam logic [2:0] S_SPUT   = 3'd2;
  localparam logic [2:0] S_WSTART = 3'd3;
  localparam logic [2:0] S_WEVAL  = 3'd4;
  localparam logic [2:0] S_WFLUSH = 3'd5;

  logic [2:0]    state, state_next;
  logic [OP_W-1:0] op;
  logic [CW-1:0] cnt, cnt_next;
  logic          dropped, dropped_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] i, i_next;
  logic [EW-1:0] new_ent, new_ent_next;
  logic          last_pend, last_pend_next;
  logic          in_first, in_first_next;
  logic          in_second, in_second_next;
  logic          in_comb, in_comb_next;
  logic          have_pend, have_pend_next;
  result_t       pend, pend_next;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data, in_ent;
  logic          push, can_push;
  result_t       push_res;

  logic              hit_accept;
  logic [DIST_W-1:0] rd_dist, new_dist;
  logic [TAG_W-1:0]  rd_tag;
  logic              rd_side, rd_enter;
  logic              nf, ns, now, change;

  // entry layout: side, entering, tag, distance
  assign in_ent = {hits.from_second, hits.hit_entering, hits.hit_tag, hits.hit_distance};
  assign rd_dist  = rd_data[DIST_W-1:0];
  assign rd_tag   = rd_data[DIST_W+TAG_W-1:DIST_W];
  assign rd_enter = rd_data[EW-2];
  assign rd_side  = rd_data[EW-1];
  assign new_dist = new_ent[DIST_W-1:0];

  assign hits.ready = (state == S_IDLE);
  assign hit_accept = hits.valid && hits.ready;
  assign cfg.ready  = 1'b1;

  // child and combined inside-ness after the hit at the read port
  assign nf     = rd_side ? in_first : rd_enter;
  assign ns     = rd_side ? rd_enter : in_second;
  assign now    = combine(op, nf, ns);
  assign change = (now != in_comb);

  // operation register
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_UNION;
    end else if (cfg.valid) begin
      op <= cfg.operation;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    dropped_next   = dropped;
    j_next         = j;
    i_next         = i;
    new_ent_next   = new_ent;
    last_pend_next = last_pend;
    in_first_next  = in_first;
    in_second_next = in_second;
    in_comb_next   = in_comb;
    have_pend_next = have_pend;
    pend_next      = pend;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = new_ent;
    rd_en          = 1'b0;
    rd_addr        = '0;
    push           = 1'b0;
    push_res       = pend;
    unique case (state)
      S_IDLE: begin
        if (hit_accept) begin
          new_ent_next   = in_ent;
          last_pend_next = hits.last_hit;
          state_next     = hits.last_hit ? S_WSTART : S_IDLE;
          if (hits.carries_hit) begin
            if (cnt == CW'(HITS)) begin
              dropped_next = 1'b1;
            end else if (cnt == '0) begin
              wr_en    = 1'b1;
              wr_data  = in_ent;
              cnt_next = cnt + 1'b1;
            end else begin
              j_next     = cnt;
              rd_en      = 1'b1;
              rd_addr    = AW'(cnt - 1'b1);
              state_next = S_SCMP;
            end
          end
        end
      end
      S_SCMP: begin
        // shift the older hit up while it lies strictly farther
        if ($signed(rd_dist) > $signed(new_dist)) begin
          wr_en   = 1'b1;
          wr_addr = AW'(j);
          wr_data = rd_data;
          j_next  = j - 1'b1;
          if (j == CW'(1)) begin
            state_next = S_SPUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(j - CW'(2));
          end
        end else begin
          wr_en      = 1'b1;
          wr_addr    = AW'(j);
          cnt_next   = cnt + 1'b1;
          state_next = last_pend ? S_WSTART : S_IDLE;
        end
      end
      S_SPUT: begin
        wr_en      = 1'b1;
        wr_addr    = AW'(j);
        cnt_next   = cnt + 1'b1;
        state_next = last_pend ? S_WSTART : S_IDLE;
      end
      S_WSTART: begin
        in_first_next  = 1'b0;
        in_second_next = 1'b0;
        in_comb_next   = 1'b0;
        have_pend_next = 1'b0;
        if (cnt == '0) begin
          state_next = S_WFLUSH;
        end else begin
          rd_en      = 1'b1;
          i_next     = '0;
          state_next = S_WEVAL;
        end
      end
      S_WEVAL: begin
        // hold when a crossing needs the output slot and it is full
        if (!(change && have_pend && !can_push)) begin
          in_first_next  = nf;
          in_second_next = ns;
          in_comb_next   = now;
          if (change) begin
            push                  = have_pend;
            pend_next.distance    = rd_dist;
            pend_next.entering    = now;
            pend_next.tag         = rd_tag;
            pend_next.no_crossing = 1'b0;
            pend_next.overflowed  = dropped;
            pend_next.last_result = 1'b0;
            have_pend_next        = 1'b1;
          end
          if (CW'(i + 1'b1) == cnt) begin
            state_next = S_WFLUSH;
          end else begin
            i_next  = i + 1'b1;
            rd_en   = 1'b1;
            rd_addr = AW'(i + 1'b1);
          end
        end
      end
      S_WFLUSH: begin
        if (have_pend) begin
          push_res.last_result = 1'b1;
        end else begin
          push_res.distance    = '0;
          push_res.entering    = 1'b0;
          push_res.tag         = '0;
          push_res.no_crossing = 1'b1;
          push_res.overflowed  = dropped;
          push_res.last_result = 1'b1;
        end
        if (can_push) begin
          push           = 1'b1;
          cnt_next       = '0;
          dropped_next   = 1'b0;
          in_first_next  = 1'b0;
          in_second_next = 1'b0;
          in_comb_next   = 1'b0;
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      dropped   <= 1'b0;
      in_first  <= 1'b0;
      in_second <= 1'b0;
      in_comb   <= 1'b0;
      have_pend <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      dropped   <= dropped_next;
      in_first  <= in_first_next;
      in_second <= in_second_next;
      in_comb   <= in_comb_next;
      have_pend <= have_pend_next;
      last_pend <= last_pend_next;
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    j       <= j_next;
    i       <= i_next;
    new_ent <= new_ent_next;
    pend    <= pend_next;
  end

  crhc_hit_mem #(
    .DEPTH (HITS),
    .W     (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crhc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .can_push (can_push),
    .results  (results)
  );

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HITS)) else $error("hit count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> cnt == CW'(HITS)) else $error("hit dropped with free space");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_SCMP |-> j != '0) else $error("insertion walked below entry zero");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_WFLUSH && can_push) |=> (cnt == '0 && !dropped && !have_pend))
    else $error("run state not cleared after final result");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push) else $error("result pushed into a full output register");

endmodule

// ----- rtl/core/crhc_hit_mem.sv -----
// crhc_hit_mem: hit store, one write port and one read port with registered
// read data; no dependencies
module crhc_hit_mem #(
  parameter int DEPTH = 32,
  parameter int W     = 50
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/crhc_out_reg.sv -----
// crhc_out_reg: output register of the result channel
// depends on crhc_pkg and crhc_ifs
module crhc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crhc_pkg::result_t push_res,
  output logic             can_push,
  crhc_res_if.source       results
);
  import crhc_pkg::*;

  result_t res;
  logic    res_valid;

  // slot is free when empty or being drained this cycle
  assign can_push = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_res;
    end
  end

  assign results.valid        = res_valid;
  assign results.out_distance = res.distance;
  assign results.out_entering = res.entering;
  assign results.out_tag      = res.tag;
  assign results.no_crossing  = res.no_crossing;
  assign results.overflowed   = res.overflowed;
  assign results.last_result  = res.last_result;

endmodule

// ----- verif/csg_ray_hit_combiner_checker.sv -----
`timescale 1ns / 100ps
// csg_ray_hit_combiner_checker: watches the hit, result and config channels,
// predicts the boolean crossings of every closed run and checks them in order
// depends on crhc_pkg and crhc_ifs
module csg_ray_hit_combiner_checker #(
  parameter int HITS = 32
) (
  input  logic clk,
  input  logic rst,
  crhc_hit_if  hits,
  crhc_res_if  results,
  crhc_cfg_if  cfg,
  output int   failures,
  output int   pending
);
  import crhc_pkg::*;

  // one child hit as kept for the open run
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              second;
    logic              entering;
    logic [TAG_W-1:0]  tag;
  } kept_hit_t;

  kept_hit_t       run_hits[$];
  logic            run_dropped;
  logic [OP_W-1:0] operation_q;
  result_t         crossings_due[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  // inside-ness of the combined shape for the current operation
  function automatic logic combined_inside(input logic [OP_W-1:0] op, input logic in_first,
                                           input logic in_second);
    logic inside_now;
    case (op)
      OP_UNION:     inside_now = in_first || in_second;
      OP_INTERSECT: inside_now = in_first && in_second;
      OP_SUBTRACT:  inside_now = in_first && !in_second;
      default:      inside_now = 1'b0;
    endcase
    return inside_now;
  endfunction

  // sort the run by distance, walk it and queue the crossings it yields
  task automatic close_run();
    kept_hit_t order[$];
    kept_hit_t cur;
    result_t   crossing;
    logic      in_first, in_second, comb_before, comb_after;
    int        j, first_new;
    order = run_hits;
    // stable insertion sort on signed distance
    for (int i = 1; i < order.size(); i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && $signed(order[j-1].distance) > $signed(cur.distance)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    // walk from outside both children
    in_first    = 1'b0;
    in_second   = 1'b0;
    comb_before = combined_inside(operation_q, 1'b0, 1'b0);
    first_new   = crossings_due.size();
    foreach (order[i]) begin
      if (order[i].second) begin
        in_second = order[i].entering;
      end else begin
        in_first = order[i].entering;
      end
      comb_after = combined_inside(operation_q, in_first, in_second);
      if (comb_after != comb_before) begin
        crossing            = '0;
        crossing.distance   = order[i].distance;
        crossing.entering   = comb_after;
        crossing.tag        = order[i].tag;
        crossing.overflowed = run_dropped;
        crossings_due.insert(crossings_due.size(), crossing);
      end
      comb_before = comb_after;
    end
    // a run without crossings still gives one item
    if (crossings_due.size() == first_new) begin
      crossing             = '0;
      crossing.no_crossing = 1'b1;
      crossing.overflowed  = run_dropped;
      crossings_due.insert(crossings_due.size(), crossing);
    end
    crossings_due[crossings_due.size() - 1].last_result = 1'b1;
    run_hits.delete();
    run_dropped = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] seen);
    if (seen !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  // compare one accepted result item with the oldest crossing due
  task automatic check_result();
    result_t want;
    if (crossings_due.size() == 0) begin
      failures++;
      $display("%0t: result item with none expected, expected nothing, actual %0h %b %0h %b %b %b",
               $time, results.out_distance, results.out_entering, results.out_tag,
               results.no_crossing, results.overflowed, results.last_result);
    end else begin
      want = crossings_due.pop_front();
      compare_field("out_distance", want.distance, results.out_distance);
      compare_field("out_entering", want.entering, results.out_entering);
      compare_field("out_tag", want.tag, results.out_tag);
      compare_field("no_crossing", want.no_crossing, results.no_crossing);
      compare_field("overflowed", want.overflowed, results.overflowed);
      compare_field("last_result", want.last_result, results.last_result);
    end
  endtask

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      run_hits.delete();
      crossings_due.delete();
      run_dropped = 1'b0;
      operation_q = OP_UNION;
    end else begin
      if (cfg.valid && cfg.ready) begin
        operation_q = cfg.operation;
      end
      if (results.valid && results.ready) begin
        check_result();
      end
      if (hits.valid && hits.ready) begin
        if (hits.carries_hit) begin
          if (run_hits.size() < HITS) begin
            run_hits.insert(run_hits.size(), {hits.hit_distance, hits.from_second,
                                              hits.hit_entering, hits.hit_tag});
          end else begin
            run_dropped = 1'b1;
          end
        end
        if (hits.last_hit) begin
          close_run();
        end
      end
    end
    pending = crossings_due.size();
  end

endmodule

// ----- verif/csg_ray_hit_combiner_tb.sv -----
`timescale 1ns / 100ps
// csg_ray_hit_combiner_tb: drives runs of child hits under every operation,
// with bursty input and a stalling receiver; checking lives in the checker
// depends on crhc_pkg, crhc_ifs, csg_ray_hit_combiner and its checker
module csg_ray_hit_combiner_tb;
  import crhc_pkg::*;

  localparam int              HITS         = 32;
  localparam int              PHASES       = 6;
  localparam int              PHASE_ITEMS  = 72;
  localparam int              LONG_HOLD    = 400;
  localparam int              QUIET_CYCLES = HITS + 8;
  localparam int              TIMEOUT_NS   = 5_000_000;
  localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

  // receiver stall patterns
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_e;

  // one input item as the sender builds it
  typedef struct {
    logic              carries;
    logic [DIST_W-1:0] distance;
    logic              second;
    logic              entering;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } hit_item_t;

  logic      clk = 1'b0;
  logic      rst;
  int        failures;
  int        pending;
  int        items_sent;
  int        burst_left;
  bit        steady;
  bit        hold_request;
  hit_item_t run_q[$];

  crhc_hit_if hit_ch ();
  crhc_res_if result_ch ();
  crhc_cfg_if cfg_ch ();

  csg_ray_hit_combiner #(.HITS(HITS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .hits    (hit_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  csg_ray_hit_combiner_checker #(.HITS(HITS)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .hits     (hit_ch),
    .results  (result_ch),
    .cfg      (cfg_ch),
    .failures (failures),
    .pending  (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: long hold on request, otherwise one of four stall patterns, picked anew at random
  initial begin
    int         cycle_no;
    sink_mode_e mode;
    cycle_no = 0;
    mode = SINK_OPEN;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (cycle_no % 48 == 0) begin
          mode = sink_mode_e'($urandom_range(SINK_OPEN, SINK_MOSTLY));
        end
        case (mode)
          SINK_OPEN:   result_ch.ready <= 1'b1;
          SINK_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: result_ch.ready <= (cycle_no % 4 == 3);
          default:     result_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
        cycle_no++;
        @(negedge clk);
      end
    end
  end

  function automatic hit_item_t random_hit(input logic carries);
    hit_item_t h;
    h.carries  = carries;
    h.distance = $urandom;
    h.second   = 1'($urandom_range(0, 1));
    h.entering = 1'($urandom_range(0, 1));
    h.tag      = TAG_W'($urandom_range(0, 65535));
    h.last     = 1'b0;
    return h;
  endfunction

  task automatic put(input logic carries, input logic [DIST_W-1:0] distance, input logic second,
                     input logic entering, input logic [TAG_W-1:0] tag, input logic last);
    hit_item_t h;
    h.carries  = carries;
    h.distance = distance;
    h.second   = second;
    h.entering = entering;
    h.tag      = tag;
    h.last     = last;
    run_q.insert(run_q.size(), h);
  endtask

  // optional stray marker, then close on the final hit or on a trailing marker
  task automatic close_run_q();
    hit_item_t h;
    if (run_q.size() > 0 && $urandom_range(0, 4) == 0) begin
      run_q.insert($urandom_range(0, run_q.size() - 1), random_hit(1'b0));
    end
    if (run_q.size() > 0 && $urandom_range(0, 2) != 0) begin
      h = run_q.pop_back();
    end else begin
      h = random_hit(1'b0);
    end
    h.last = 1'b1;
    run_q.insert(run_q.size(), h);
  endtask

  // enter/leave spans per child, either tightly packed for ties or spread wide
  task automatic build_spans_run(input int max_spans);
    int        spans, pick;
    bit        tight;
    int        bounds[$];
    hit_item_t h;
    for (int c = 0; c < 2; c++) begin
      spans = $urandom_range(0, max_spans);
      tight = $urandom_range(0, 1);
      bounds.delete();
      repeat (2 * spans) begin
        bounds.insert(bounds.size(), tight ? $urandom_range(0, 24) - 12 : int'($urandom));
      end
      bounds.sort();
      for (int s = 0; s < 2 * spans; s++) begin
        h = random_hit(1'b1);
        h.distance = bounds[s];
        h.second   = (c == 1);
        h.entering = (s % 2 == 0);
        run_q.insert(run_q.size(), h);
      end
    end
    // arrival order scrambled half of the time
    if ($urandom_range(0, 1) == 1) begin
      for (int i = run_q.size() - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        h = run_q[i];
        run_q[i] = run_q[pick];
        run_q[pick] = h;
      end
    end
    close_run_q();
  endtask

  // unstructured hits with every field random
  task automatic build_noise_run(input int count);
    repeat (count) run_q.insert(run_q.size(), random_hit(1'b1));
    close_run_q();
  endtask

  task automatic offer_hit(input hit_item_t h);
    hit_ch.valid        <= 1'b1;
    hit_ch.carries_hit  <= h.carries;
    hit_ch.hit_distance <= h.distance;
    hit_ch.from_second  <= h.second;
    hit_ch.hit_entering <= h.entering;
    hit_ch.hit_tag      <= h.tag;
    hit_ch.last_hit     <= h.last;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // send the built run in bursts with random gaps
  task automatic offer_run();
    int gap;
    foreach (run_q[i]) begin
      if (burst_left == 0) begin
        gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          hit_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      offer_hit(run_q[i]);
      if (run_q[i].carries || run_q[i].last) items_sent++;
    end
    run_q.delete();
  endtask

  // wait for every result, then let the block go idle
  task automatic settle();
    hit_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_operation(input logic [OP_W-1:0] op);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.operation <= op;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [OP_W-1:0] phase_op(input int p);
    case (p)
      0:       return OP_UNION;
      1:       return OP_INTERSECT;
      2:       return OP_SUBTRACT;
      3:       return OP_NONE;
      default: return OP_W'($urandom_range(OP_UNION, OP_NONE));
    endcase
  endfunction

  // directed runs: extremes, ties, markers, lone exits
  task automatic directed_runs();
    // empty run
    put(1'b0, '0, 1'b0, 1'b0, '0, 1'b1);
    // extreme distances and tags, tie at zero between the children
    put(1'b1, 32'h8000_0000, 1'b0, 1'b1, 16'h0000, 1'b0);
    put(1'b1, 32'h0000_0000, 1'b1, 1'b1, 16'h0001, 1'b0);
    put(1'b1, 32'h0000_0000, 1'b0, 1'b0, 16'h0002, 1'b0);
    put(1'b1, 32'h7fff_ffff, 1'b1, 1'b0, 16'hffff, 1'b1);
    // marker in the middle and a marker closing the run
    put(1'b1, 32'd5, 1'b0, 1'b1, 16'h0a0a, 1'b0);
    put(1'b0, 32'hffff_ffff, 1'b1, 1'b1, 16'hffff, 1'b0);
    put(1'b1, 32'd10, 1'b0, 1'b0, 16'h0b0b, 1'b0);
    put(1'b0, '0, 1'b0, 1'b0, '0, 1'b1);
    // lone exit, no crossing
    put(1'b1, 32'd7, 1'b1, 1'b0, 16'h5555, 1'b1);
    // enter and leave at the same distance
    put(1'b1, 32'd100, 1'b0, 1'b1, 16'h1234, 1'b0);
    put(1'b1, 32'd100, 1'b0, 1'b0, 16'h4321, 1'b1);
    // out-of-order arrival
    put(1'b1, 32'd50, 1'b1, 1'b0, 16'haaaa, 1'b0);
    put(1'b1, -32'sd50, 1'b1, 1'b1, 16'h00ff, 1'b0);
    put(1'b1, -32'sd10, 1'b0, 1'b1, 16'hff00, 1'b0);
    put(1'b1, 32'd60, 1'b0, 1'b0, 16'h8001, 1'b1);
    offer_run();
  endtask

  // main sequence
  initial begin
    int              budget, pick;
    bit              force_full;
    logic [OP_W-1:0] op;
    rst                 = 1'b1;
    hit_ch.valid        = 1'b0;
    hit_ch.carries_hit  = 1'b0;
    hit_ch.hit_distance = '0;
    hit_ch.from_second  = 1'b0;
    hit_ch.hit_entering = 1'b0;
    hit_ch.hit_tag      = '0;
    hit_ch.last_hit     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.operation    = OP_UNION;
    items_sent          = 0;
    burst_left          = 0;
    steady              = 1'b0;
    hold_request        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      op = phase_op(p);
      write_operation(op);
      if (p == 0) directed_runs();
      // long receiver hold while the sender keeps going
      if (p == 1) hold_request = 1'b1;
      steady = (p == 4);
      force_full = (p == 0);
      budget = items_sent + ((op == OP_NONE) ? PHASE_ITEMS / 2 : PHASE_ITEMS);
      while (items_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (force_full || pick >= 95) begin
          build_noise_run($urandom_range(HITS + 1, HITS + 6));
        end else if (pick < 60) begin
          build_spans_run(3);
        end else if (pick < 70) begin
          build_spans_run(8);
        end else if (pick < 88) begin
          build_noise_run($urandom_range(1, 8));
        end else begin
          build_noise_run(0);
        end
        force_full = 1'b0;
        offer_run();
      end
    end

    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
